/* rtl/thermistor_adc_to_temperature_lut_assert.svh */
// Assertion macros for the thermistor lookup block.
// Needs clk and rst_n in scope at the point of use.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_LUT_ASSERT_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_LUT_ASSERT_SVH
`ifndef SYNTH
`define TLUT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tlut assertion failed");
`define TLUT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlut implication failed");
`else
`define TLUT_ASSERT(lbl, prop)
`define TLUT_IMPLY(lbl, ante, cons)
`endif
`endif

/* rtl/tlut_pkg.sv */
// Shared types, constants and resistance table for the thermistor lookup.
// No dependencies.
package tlut_pkg;
    localparam int NUM_W   = 36;
    localparam int DEN_W   = 16;
    localparam int ROM_W   = 20;
    localparam int ENTRIES = 206;
    localparam int IDX_W   = 8;
    localparam int TEMP_W  = 17;
    localparam int RES_W   = 24;

    localparam logic signed [31:0] TEMP_COLD_C = -32'sd55;
    localparam logic signed [31:0] TEMP_HOT_C  = 32'sd150;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_COLD    = 2'd1;
    localparam logic [1:0] ST_HOT     = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic [1:0] REG_LOAD = 2'd0;
    localparam logic [1:0] REG_FS   = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    typedef struct packed {
        logic [19:0] load_resistance;
        logic [15:0] adc_full_scale;
        logic        divider_mode;
    } cfg_t;

    // Nominal resistance, -55 C to 150 C in 1 C steps, strictly descending.
    localparam logic [ROM_W-1:0] ROM_RES [0:ENTRIES-1] = '{
        20'd953774, 20'd886261, 20'd823959, 20'd766433, 20'd713290, 20'd664169,
        20'd618743, 20'd576711, 20'd537801, 20'd501761, 20'd468363, 20'd437399,
        20'd408676, 20'd382019, 20'd357268, 20'd334274, 20'd312904, 20'd293034,
        20'd274548, 20'd257343, 20'd241323, 20'd226399, 20'd212490, 20'd199521,
        20'd187423, 20'd176133, 20'd165591, 20'd155746, 20'd146545, 20'd137944,
        20'd129900, 20'd122374, 20'd115329, 20'd108732, 20'd102553, 20'd96761,
        20'd91332, 20'd86239, 20'd81461, 20'd76976, 20'd72765, 20'd68809,
        20'd65091, 20'd61596, 20'd58310, 20'd55218, 20'd52308, 20'd49569,
        20'd46989, 20'd44559, 20'd42268, 20'd40108, 20'd38071, 20'd36150,
        20'd34336, 20'd32624, 20'd31007, 20'd29480, 20'd28036, 20'd26672,
        20'd25381, 20'd24161, 20'd23006, 20'd21912, 20'd20877, 20'd19897,
        20'd18968, 20'd18088, 20'd17253, 20'd16462, 20'd15711, 20'd14999,
        20'd14323, 20'd13681, 20'd13072, 20'd12493, 20'd11943, 20'd11420,
        20'd10923, 20'd10450, 20'd10000, 20'd9572, 20'd9165, 20'd8777,
        20'd8408, 20'd8056, 20'd7721, 20'd7401, 20'd7097, 20'd6807,
        20'd6530, 20'd6266, 20'd6014, 20'd5773, 20'd5543, 20'd5324,
        20'd5114, 20'd4914, 20'd4723, 20'd4540, 20'd4365, 20'd4198,
        20'd4038, 20'd3885, 20'd3739, 20'd3599, 20'd3465, 20'd3336,
        20'd3213, 20'd3095, 20'd2982, 20'd2874, 20'd2770, 20'd2671,
        20'd2575, 20'd2484, 20'd2396, 20'd2312, 20'd2231, 20'd2153,
        20'd2079, 20'd2007, 20'd1938, 20'd1872, 20'd1809, 20'd1748,
        20'd1689, 20'd1633, 20'd1578, 20'd1526, 20'd1476, 20'd1428,
        20'd1381, 20'd1336, 20'd1293, 20'd1252, 20'd1212, 20'd1173,
        20'd1136, 20'd1101, 20'd1066, 20'd1033, 20'd1001, 20'd970,
        20'd940, 20'd912, 20'd884, 20'd857, 20'd831, 20'd806,
        20'd782, 20'd759, 20'd737, 20'd715, 20'd694, 20'd674,
        20'd655, 20'd636, 20'd618, 20'd600, 20'd583, 20'd566,
        20'd550, 20'd535, 20'd520, 20'd506, 20'd492, 20'd478,
        20'd465, 20'd452, 20'd440, 20'd428, 20'd417, 20'd406,
        20'd395, 20'd384, 20'd374, 20'd364, 20'd355, 20'd346,
        20'd337, 20'd328, 20'd320, 20'd311, 20'd304, 20'd296,
        20'd288, 20'd281, 20'd274, 20'd267, 20'd261, 20'd254,
        20'd248, 20'd242, 20'd236, 20'd230, 20'd225, 20'd219,
        20'd214, 20'd209, 20'd204, 20'd199, 20'd195, 20'd190,
        20'd186, 20'd181
    };
endpackage

/* rtl/tlut_regs.sv */
// Configuration register file on an APB-style port.
// Depends on tlut_pkg.
module tlut_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tlut_pkg::cfg_t     cfg
);
    import tlut_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_LOAD: cfg_next.load_resistance = pwdata[19:0];
                REG_FS:   cfg_next.adc_full_scale  = pwdata[15:0];
                REG_MODE: cfg_next.divider_mode    = pwdata[0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_LOAD: prdata = {12'd0, cfg_reg.load_resistance};
            REG_FS:   prdata = {16'd0, cfg_reg.adc_full_scale};
            REG_MODE: prdata = {31'd0, cfg_reg.divider_mode};
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.load_resistance <= 20'd10000;
            cfg_reg.adc_full_scale  <= 16'd4095;
            cfg_reg.divider_mode    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

/* rtl/tlut_mul.sv */
// Registered 20 x 16 unsigned multiplier shared by all product steps.
// Depends on tlut_pkg.
module tlut_mul (
    input  logic                       clk,
    input  logic [tlut_pkg::ROM_W-1:0] x,
    input  logic [tlut_pkg::DEN_W-1:0] y,
    output logic [tlut_pkg::NUM_W-1:0] prod
);
    import tlut_pkg::*;

    logic [NUM_W-1:0] prod_reg;
    logic [NUM_W-1:0] prod_next;

    assign prod_next = NUM_W'(x) * NUM_W'(y);
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end
endmodule

/* rtl/tlut_alu.sv */
// Shared compare and subtract unit: difference and a >= b flag.
// No dependencies.
module tlut_alu #(
    parameter int W = 51
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);
    logic [W:0] wide;

    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[W-1:0];
    assign ge   = !wide[W];
endmodule

/* rtl/thermistor_adc_to_temperature_lut.sv */
// Thermistor sample to temperature: sequencer around a shared subtractor and multiplier.
// Depends on tlut_pkg, tlut_regs, tlut_mul, tlut_alu and the assertion header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready always high)
//  sample   | start && !busy       | adc_sample
//  result   | done (one cycle)     | temperature_q8, thermistor_res, status
//
// An invalid sample raises done on the cycle after it is accepted; busy stays low.
// A valid sample holds busy through the product, a 36-step restoring quotient and the
// clamp checks, where a cold or hot clamp ends it; inside the table it goes on through
// 7 or 8 binary-search probes, the interpolation terms, a FRAC_BITS+1 step fraction and
// a finish step. done follows on the cycle busy falls. Results cannot be stalled.
// Reset restores the register defaults and idles the sequencer.
`include "thermistor_adc_to_temperature_lut_assert.svh"
module thermistor_adc_to_temperature_lut #(
    parameter int FRAC_BITS   = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        adc_sample,
    output logic               done,
    output logic signed [16:0] temperature_q8,
    output logic [23:0]        thermistor_res,
    output logic [1:0]         status
);
    import tlut_pkg::*;

    localparam int QW = NUM_W + DEN_W - 1;
    localparam int FW = NUM_W + 1 + FRAC_BITS;
    localparam int UW = (QW > FW) ? QW : FW;
    localparam int CW = 6;

    typedef enum logic [3:0] {
        S_IDLE, S_NUM, S_QLD, S_QDIV, S_COLD_M, S_COLD_C, S_HOT_M, S_HOT_C,
        S_SRCH_M, S_SRCH_C, S_N_M, S_N_C, S_D_M, S_D_C, S_FDIV, S_FIN
    } state_t;

    cfg_t               cfg;
    state_t             state_reg, state_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [DEN_W-1:0]   mult_reg, mult_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [UW-1:0]      rem_reg, rem_next;
    logic [UW-1:0]      div_reg, div_next;
    logic [NUM_W-1:0]   q_reg, q_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]   lo_reg, lo_next;
    logic [IDX_W-1:0]   hi_reg, hi_next;
    logic [TEMP_W-1:0]  temp_reg, temp_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic [1:0]         status_reg, status_next;
    logic               done_reg, done_next;

    logic [DEN_W-1:0]   a_in;
    logic [DEN_W-1:0]   fs_minus_a;
    logic               invalid;
    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [ROM_W-1:0]   mul_x;
    logic [NUM_W-1:0]   prod;
    logic [UW-1:0]      alu_a, alu_b, alu_diff;
    logic               alu_ge;
    logic signed [31:0] whole;
    logic signed [31:0] tval;
    logic signed [31:0] cold_val;
    logic signed [31:0] hot_val;

    tlut_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlut_mul u_mul (
        .clk  (clk),
        .x    (mul_x),
        .y    ((state_reg == S_NUM) ? mult_reg : den_reg),
        .prod (prod)
    );

    tlut_alu #(.W(UW)) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    assign a_in       = DEN_W'(adc_sample[SAMPLE_BITS-1:0]);
    assign fs_minus_a = cfg.adc_full_scale - a_in;
    assign invalid    = (a_in == '0) || (a_in >= cfg.adc_full_scale)
                        || (cfg.load_resistance == '0);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[IDX_W:1];

    assign whole    = TEMP_COLD_C + signed'(32'(lo_reg));
    assign tval     = (whole <<< FRAC_BITS) + signed'(32'(q_reg[FRAC_BITS:0]));
    assign cold_val = TEMP_COLD_C <<< FRAC_BITS;
    assign hot_val  = TEMP_HOT_C <<< FRAC_BITS;

    always_comb
    begin
        case (state_reg)
            S_NUM:    mul_x = cfg.load_resistance;
            S_COLD_M: mul_x = ROM_RES[0];
            S_HOT_M:  mul_x = ROM_RES[ENTRIES-1];
            S_SRCH_M: mul_x = ROM_RES[mid];
            S_N_M:    mul_x = ROM_RES[lo_reg];
            S_D_M:    mul_x = ROM_RES[lo_reg] - ROM_RES[hi_reg];
            default:  mul_x = '0;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_QDIV, S_FDIV:
            begin
                alu_a = rem_reg;
                alu_b = div_reg;
            end
            S_COLD_C, S_SRCH_C:
            begin
                alu_a = UW'(num_reg);
                alu_b = UW'(prod);
            end
            S_HOT_C, S_N_C:
            begin
                alu_a = UW'(prod);
                alu_b = UW'(num_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        den_next    = den_reg;
        mult_next   = mult_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        temp_next   = temp_reg;
        res_next    = res_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (invalid)
                    begin
                        temp_next   = '0;
                        res_next    = '0;
                        status_next = ST_INVALID;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        den_next   = cfg.divider_mode ? a_in : fs_minus_a;
                        mult_next  = cfg.divider_mode ? fs_minus_a : a_in;
                        state_next = S_NUM;
                    end
                end
            end
            S_NUM: state_next = S_QLD;
            S_QLD:
            begin
                num_next   = prod;
                rem_next   = UW'(prod);
                div_next   = UW'(den_reg) << (NUM_W - 1);
                q_next     = '0;
                cnt_next   = CW'(NUM_W - 1);
                state_next = S_QDIV;
            end
            S_QDIV, S_FDIV:
            begin
                // one restoring step: subtract when it fits, shift in the bit
                if (alu_ge)
                begin
                    rem_next = alu_diff;
                end
                q_next   = {q_reg[NUM_W-2:0], alu_ge};
                div_next = div_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = (state_reg == S_QDIV) ? S_COLD_M : S_FIN;
                end
            end
            S_COLD_M:
            begin
                res_next   = (q_reg[NUM_W-1:RES_W] != '0) ? '1 : q_reg[RES_W-1:0];
                state_next = S_COLD_C;
            end
            S_COLD_C:
            begin
                if (alu_ge)
                begin
                    temp_next   = cold_val[TEMP_W-1:0];
                    status_next = ST_COLD;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_HOT_M;
                end
            end
            S_HOT_M: state_next = S_HOT_C;
            S_HOT_C:
            begin
                if (alu_ge)
                begin
                    temp_next   = hot_val[TEMP_W-1:0];
                    status_next = ST_HOT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = IDX_W'(ENTRIES - 1);
                    state_next = (ENTRIES > 2) ? S_SRCH_M : S_N_M;
                end
            end
            S_SRCH_M: state_next = S_SRCH_C;
            S_SRCH_C:
            begin
                // narrow the bracket until lo and hi are neighbors
                if (alu_ge)
                begin
                    hi_next    = mid;
                    state_next = ((mid - lo_reg) > IDX_W'(1)) ? S_SRCH_M : S_N_M;
                end
                else
                begin
                    lo_next    = mid;
                    state_next = ((hi_reg - mid) > IDX_W'(1)) ? S_SRCH_M : S_N_M;
                end
            end
            S_N_M: state_next = S_N_C;
            S_N_C:
            begin
                rem_next   = alu_diff;
                state_next = S_D_M;
            end
            S_D_M: state_next = S_D_C;
            S_D_C:
            begin
                // dividend n*2^(F+1) + d, divisor 2d aligned to the top quotient bit
                rem_next   = (rem_reg << (FRAC_BITS + 1)) + UW'(prod);
                div_next   = UW'(prod) << (FRAC_BITS + 1);
                q_next     = '0;
                cnt_next   = CW'(FRAC_BITS);
                state_next = S_FDIV;
            end
            S_FIN:
            begin
                temp_next   = tval[TEMP_W-1:0];
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            den_reg    <= '0;
            mult_reg   <= '0;
            num_reg    <= '0;
            rem_reg    <= '0;
            div_reg    <= '0;
            q_reg      <= '0;
            cnt_reg    <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            temp_reg   <= '0;
            res_reg    <= '0;
            status_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            den_reg    <= den_next;
            mult_reg   <= mult_next;
            num_reg    <= num_next;
            rem_reg    <= rem_next;
            div_reg    <= div_next;
            q_reg      <= q_next;
            cnt_reg    <= cnt_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            temp_reg   <= temp_next;
            res_reg    <= res_next;
            status_reg <= status_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign temperature_q8 = signed'(temp_reg);
    assign thermistor_res = res_reg;
    assign status         = status_reg;

    `TLUT_IMPLY(a_done_idle, done, !busy)
    `TLUT_IMPLY(a_invalid_zero, done && (status == ST_INVALID),
        (thermistor_res == '0) && (temperature_q8 == '0))
    `TLUT_IMPLY(a_bracket, (state_reg == S_SRCH_M) || (state_reg == S_SRCH_C),
        lo_reg < hi_reg)
    `TLUT_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start))
endmodule

/* test/tb_thermistor_adc_to_temperature_lut.sv */
// Testbench for the thermistor sample to temperature lookup block.
// Uses tlut_pkg; a local model predicts temperature, resistance and status per sample.
module tb_thermistor_adc_to_temperature_lut;
    import tlut_pkg::*;

    class temp_scoreboard;
        logic [19:0] load_res;
        logic [15:0] full_scale;
        logic        mode;
        logic signed [16:0] exp_temp[$];
        logic [23:0] exp_res[$];
        logic [1:0]  exp_status[$];
        int errors;

        function new();
            load_res = 20'd10000;
            full_scale = 16'd4095;
            mode = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == REG_LOAD)
                load_res = val[19:0];
            else if (idx == REG_FS)
                full_scale = val[15:0];
            else if (idx == REG_MODE)
                mode = val[0];
        endfunction

        function void note_sample(logic [15:0] sample);
            longint unsigned num, den, q, r1, r2, n, d, f;
            logic signed [16:0] t;
            logic [1:0] st;
            logic [23:0] res;
            bit hit;
            t = '0;
            res = '0;
            st = ST_INVALID;
            if (sample != 0 && sample < full_scale && load_res != 0)
            begin
                if (mode == 1'b0)
                begin
                    num = longint'(load_res) * sample;
                    den = full_scale - sample;
                end
                else
                begin
                    num = longint'(load_res) * (full_scale - sample);
                    den = sample;
                end
                q = num / den;
                res = (q > 64'd16777215) ? 24'hFFFFFF : q[23:0];
                if (num >= longint'(ROM_RES[0]) * den)
                begin
                    t = -17'sd55 * 256;
                    st = ST_COLD;
                end
                else if (num <= longint'(ROM_RES[ENTRIES-1]) * den)
                begin
                    t = 17'sd150 * 256;
                    st = ST_HOT;
                end
                else
                begin
                    hit = 0;
                    for (int i = 0; i + 1 < ENTRIES && !hit; i++)
                    begin
                        r1 = ROM_RES[i];
                        r2 = ROM_RES[i+1];
                        if (num >= r2 * den)
                        begin
                            n = r1 * den - num;
                            d = (r1 - r2) * den;
                            f = ((n << 8) * 2 + d) / (2 * d);
                            t = 17'((-55 + i) * 256 + int'(f));
                            st = ST_OK;
                            hit = 1;
                        end
                    end
                end
            end
            exp_temp.push_back(t);
            exp_res.push_back(res);
            exp_status.push_back(st);
        endfunction

        function void check_result(logic signed [16:0] t, logic [23:0] r, logic [1:0] s);
            logic signed [16:0] et;
            logic [23:0] er;
            logic [1:0] es;
            if (exp_temp.size() == 0)
            begin
                $error("unexpected result beat: temp %0d res %0d status %0d", t, r, s);
                errors++;
                return;
            end
            et = exp_temp.pop_front();
            er = exp_res.pop_front();
            es = exp_status.pop_front();
            if (t !== et)
            begin
                $error("temperature_q8 expected %0d got %0d", et, t);
                errors++;
            end
            if (r !== er)
            begin
                $error("thermistor_res expected %0d got %0d", er, r);
                errors++;
            end
            if (s !== es)
            begin
                $error("status expected %0d got %0d", es, s);
                errors++;
            end
        endfunction

        function int pending();
            return exp_temp.size();
        endfunction
    endclass

    logic clk, rst_n, psel, penable, pwrite, pready, start, busy, done;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic [15:0] adc_sample;
    logic signed [16:0] temperature_q8;
    logic [23:0] thermistor_res;
    logic [1:0]  status;

    temp_scoreboard sb = new();

    thermistor_adc_to_temperature_lut dut (.*);

    initial clk = 0;
    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result(temperature_q8, thermistor_res, status);

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.set_reg(idx, val);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    // Keep start high into the next beat when no gap follows.
    task automatic send_sample(logic [15:0] s);
        start <= 1;
        adc_sample <= s;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_sample(s);
        if ($urandom_range(0, 2) != 0)
        begin
            start <= 0;
            idle_gap();
        end
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Mostly samples inside the valid window, with some edge and garbage codes.
    function automatic logic [15:0] pick_sample();
        int unsigned fs;
        fs = sb.full_scale;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'd0;
            2: return 16'(fs);
            3: return (fs > 1) ? 16'(fs - 1) : 16'd1;
            default: return (fs > 1) ? 16'($urandom_range(1, fs - 1)) : 16'($urandom);
        endcase
    endfunction

    task automatic config_phase(logic [31:0] lr, logic [31:0] fs, logic [31:0] md);
        drain();
        write_reg(REG_LOAD, lr);
        write_reg(REG_FS, fs);
        write_reg(REG_MODE, md);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        start = 0; adc_sample = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: invalid codes, both clamps, table points, large resistance.
        send_sample(16'd0);
        send_sample(16'd4095);
        send_sample(16'hFFFF);
        send_sample(16'd1);
        send_sample(16'd4094);
        send_sample(16'd2047);
        send_sample(16'd2048);
        send_sample(16'd4000);
        send_sample(16'd100);
        config_phase(32'hFFFFF, 32'hFFFF, 1);
        send_sample(16'd1);
        send_sample(16'hFFFE);
        send_sample(16'h8000);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        config_phase(32'hFFFFF, 32'hFFFF, 0);
        send_sample(16'hFFFE);
        send_sample(16'd1);
        send_sample(16'h7FFF);
        config_phase(1, 1, 0);
        send_sample(16'd0);
        send_sample(16'd1);
        config_phase(1, 2, 1);
        send_sample(16'd1);

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph % 3)
                0: config_phase(10000, 4095, $urandom_range(0, 1));
                1: config_phase($urandom_range(1, 20'hFFFFF), $urandom_range(2, 16'hFFFF),
                                $urandom_range(0, 1));
                default: config_phase($urandom_range(1000, 100000),
                                      $urandom_range(255, 65535), $urandom_range(0, 1));
            endcase
            repeat (50) send_sample(pick_sample());
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
